FILE: rtl/msd_pkg.sv
// Package with the widths, reset values and helpers shared by the dispatch block files.
`default_nettype none

package msd_pkg;

	localparam int DEF_MAX_SERVERS = 16;

	localparam int ARR_W   = 20;
	localparam int SVC_W   = 16;
	localparam int CNT_W   = 5;
	localparam int IDX_O_W = 4;
	localparam int STAT_W  = 32;

	localparam logic [CNT_W-1:0] SRV_CNT_RST = CNT_W'(16);

	// Adds two 32-bit values and clamps the result at all ones on overflow.
	function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
			input logic [STAT_W-1:0] b);
		logic [STAT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
	endfunction

endpackage : msd_pkg

`default_nettype wire

FILE: rtl/msd_if.sv
// Valid/ready channel interfaces for the job input and the dispatch result.
`default_nettype none

interface msd_job_if
	import msd_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [ARR_W-1:0] arrival;
	logic [SVC_W-1:0] service_time;

	modport source (output valid, output arrival, output service_time, input ready);
	modport sink   (input valid, input arrival, input service_time, output ready);
endinterface : msd_job_if

interface msd_result_if
	import msd_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [IDX_O_W-1:0] server_index;
	logic [STAT_W-1:0]  job_wait;
	logic [STAT_W-1:0]  job_finish;
	logic [STAT_W-1:0]  server_jobs;
	logic [STAT_W-1:0]  wait_total;
	logic [STAT_W-1:0]  wait_peak;
	logic [STAT_W-1:0]  finish_latest;
	logic [STAT_W-1:0]  jobs_seen;

	modport source (output valid, output server_index, output job_wait, output job_finish,
		output server_jobs, output wait_total, output wait_peak, output finish_latest,
		output jobs_seen, input ready);
	modport sink   (input valid, input server_index, input job_wait, input job_finish,
		input server_jobs, input wait_total, input wait_peak, input finish_latest,
		input jobs_seen, output ready);
endinterface : msd_result_if

`default_nettype wire

FILE: rtl/multi_server_dispatch.sv
// Top level of the single-queue, multi-server, earliest-free job dispatcher.
`default_nettype none

// Each job transaction carries an arrival time and a service time and is assigned to one of
// the active servers: the lowest-numbered server that is already free at the arrival time,
// or, when none is free, the server that frees earliest (lowest number on a tie). One result
// transaction comes back per job, with the chosen server, the wait, the finish time, that
// server's job count and the running statistics. A job's result is registered after a scan
// of the active servers: the free times sit in a memory that is read one server per cycle,
// each read word passes through one shared compare stage, and the drain, calc and update
// states then drain that read, form the finish time and update the stores. The input becomes
// ready again in the cycle after the update. The job input is not ready while a job is in
// flight; a finished result waits in the output register while the next job is accepted and
// scanned, and that next job holds in its update state until the output register is empty
// or being read. server_count is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, and the block itself does not enforce this. Zero acts as
// one server and values above MAX_SERVERS act as MAX_SERVERS. All stores read as zero after
// reset, so no clearing pass is needed.
module multi_server_dispatch
	import msd_pkg::*;
#(
	parameter int MAX_SERVERS = DEF_MAX_SERVERS
) (
	input  wire                clk,
	input  wire                arst_n,
	msd_job_if.sink            job,
	msd_result_if.source       result,
	input  wire                cfg_we,
	input  wire  [CNT_W-1:0]   cfg_data
);

	// Server index width, and a count width able to hold both the register and MAX_SERVERS.
	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int SC_W0 = $clog2(MAX_SERVERS + 1);
	localparam int SC_W  = (SC_W0 > CNT_W) ? SC_W0 : CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CALC,
		ST_UPD
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  server_count_q;
	logic [ARR_W-1:0]  arr_q;
	logic [SVC_W-1:0]  svc_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic              chk_vld_q;
	logic [IDX_W-1:0]  chk_idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  found_idx_q;
	logic              first_q;
	logic [STAT_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [IDX_W-1:0]  pick_q;
	logic [STAT_W-1:0] wait_q;
	logic [STAT_W-1:0] finish_q;
	logic [MAX_SERVERS-1:0] vld_q;

	logic [STAT_W-1:0] wait_sum_q;
	logic [STAT_W-1:0] wait_max_q;
	logic [STAT_W-1:0] finish_max_q;
	logic [STAT_W-1:0] job_count_q;

	logic               out_vld_q;
	logic [IDX_O_W-1:0] out_idx_q;
	logic [STAT_W-1:0]  out_wait_q;
	logic [STAT_W-1:0]  out_finish_q;
	logic [STAT_W-1:0]  out_jobs_q;
	logic [STAT_W-1:0]  out_wsum_q;
	logic [STAT_W-1:0]  out_wmax_q;
	logic [STAT_W-1:0]  out_fmax_q;
	logic [STAT_W-1:0]  out_cnt_q;

	// Per-server memories; an entry without its valid bit reads as zero.
	logic [STAT_W-1:0] free_mem   [MAX_SERVERS];
	logic [STAT_W-1:0] served_mem [MAX_SERVERS];
	logic [STAT_W-1:0] free_rd_q;
	logic [STAT_W-1:0] served_rd_q;

	// Active server count, clamped to one..MAX_SERVERS.
	logic [SC_W-1:0]  sc_ext;
	logic [SC_W-1:0]  active;
	logic [IDX_W-1:0] last_idx;
	logic             job_acc;

	assign sc_ext   = SC_W'(server_count_q);
	assign active   = (sc_ext == '0) ? SC_W'(1) :
	                  (sc_ext > SC_W'(MAX_SERVERS)) ? SC_W'(MAX_SERVERS) : sc_ext;
	assign last_idx = IDX_W'(active - SC_W'(1));
	assign job.ready = (state_q == ST_IDLE);
	assign job_acc   = job.valid && job.ready;

	// The shared compare stage: one stored free time against the arrival and the running best.
	logic [STAT_W-1:0] arr_ext;
	logic              hit_free;
	logic              new_best;

	assign arr_ext  = STAT_W'(arr_q);
	assign hit_free = free_rd_q <= arr_ext;
	assign new_best = first_q || (free_rd_q < best_q);

	// Choice of server and base time once the scan is complete.
	logic [IDX_W-1:0]  pick_c;
	logic [STAT_W-1:0] base_c;
	logic [STAT_W-1:0] wait_c;

	assign pick_c = found_q ? found_idx_q : best_idx_q;
	assign base_c = found_q ? arr_ext : best_q;
	assign wait_c = found_q ? '0 : (best_q - arr_ext);

	// Store updates for the current job, applied when the output register can take it.
	logic              upd_go;
	logic [STAT_W-1:0] served_new;
	logic [STAT_W-1:0] wait_sum_new;
	logic [STAT_W-1:0] wait_max_new;
	logic [STAT_W-1:0] finish_max_new;
	logic [STAT_W-1:0] job_count_new;

	assign upd_go         = (state_q == ST_UPD) && (!out_vld_q || result.ready);
	assign served_new     = sat_add(served_rd_q, STAT_W'(1));
	assign wait_sum_new   = sat_add(wait_sum_q, wait_q);
	assign wait_max_new   = (wait_q > wait_max_q) ? wait_q : wait_max_q;
	assign finish_max_new = (finish_q > finish_max_q) ? finish_q : finish_max_q;
	assign job_count_new  = sat_add(job_count_q, STAT_W'(1));

	// Memory reads and writes. Free times are read at the scan address, the served count at
	// the chosen server during the finish calculation.
	always_ff @(posedge clk) begin
		free_rd_q <= vld_q[rd_idx_q] ? free_mem[rd_idx_q] : '0;
		if (state_q == ST_CALC) begin
			served_rd_q <= vld_q[pick_c] ? served_mem[pick_c] : '0;
		end
		if (upd_go) begin
			free_mem[pick_q]   <= finish_q;
			served_mem[pick_q] <= served_new;
		end
	end

	// Sequencer, statistics and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			server_count_q <= SRV_CNT_RST;
			rd_idx_q       <= '0;
			chk_vld_q      <= 1'b0;
			found_q        <= 1'b0;
			first_q        <= 1'b1;
			vld_q          <= '0;
			wait_sum_q     <= '0;
			wait_max_q     <= '0;
			finish_max_q   <= '0;
			job_count_q    <= '0;
			out_vld_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				server_count_q <= cfg_data;
			end

			if (result.ready && !upd_go) begin
				out_vld_q <= 1'b0;
			end

			if (chk_vld_q) begin
				if (!found_q && hit_free) begin
					found_q     <= 1'b1;
					found_idx_q <= chk_idx_q;
				end
				if (new_best) begin
					best_q     <= free_rd_q;
					best_idx_q <= chk_idx_q;
				end
				first_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					chk_vld_q <= 1'b0;
					if (job_acc) begin
						arr_q      <= job.arrival;
						svc_q      <= job.service_time;
						last_idx_q <= last_idx;
						rd_idx_q   <= '0;
						found_q    <= 1'b0;
						first_q    <= 1'b1;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// The word read at rd_idx_q is compared in the following cycle.
					chk_vld_q <= 1'b1;
					chk_idx_q <= rd_idx_q;
					if (rd_idx_q == last_idx_q) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					chk_vld_q <= 1'b0;
					state_q   <= ST_CALC;
				end
				ST_CALC: begin
					pick_q   <= pick_c;
					wait_q   <= wait_c;
					finish_q <= sat_add(base_c, STAT_W'(svc_q));
					state_q  <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						vld_q[pick_q] <= 1'b1;
						wait_sum_q    <= wait_sum_new;
						wait_max_q    <= wait_max_new;
						finish_max_q  <= finish_max_new;
						job_count_q   <= job_count_new;
						out_vld_q     <= 1'b1;
						out_idx_q     <= IDX_O_W'(pick_q);
						out_wait_q    <= wait_q;
						out_finish_q  <= finish_q;
						out_jobs_q    <= served_new;
						out_wsum_q    <= wait_sum_new;
						out_wmax_q    <= wait_max_new;
						out_fmax_q    <= finish_max_new;
						out_cnt_q     <= job_count_new;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_vld_q;
	assign result.server_index  = out_idx_q;
	assign result.job_wait      = out_wait_q;
	assign result.job_finish    = out_finish_q;
	assign result.server_jobs   = out_jobs_q;
	assign result.wait_total    = out_wsum_q;
	assign result.wait_peak     = out_wmax_q;
	assign result.finish_latest = out_fmax_q;
	assign result.jobs_seen     = out_cnt_q;

endmodule : multi_server_dispatch

`default_nettype wire
